@@ hdl/miex_pkg.sv @@
// miex_pkg: shared types and constants for the MIPS integer execute unit.
// Holds opcode/funct codes, the ALU operation enum and the front-to-back request.
// No dependencies; compiled first.
package miex_pkg;

  // Primary opcodes
  localparam logic [5:0] OPC_RTYPE = 6'h00;
  localparam logic [5:0] OPC_ADDI  = 6'h08;
  localparam logic [5:0] OPC_ADDIU = 6'h09;
  localparam logic [5:0] OPC_LW    = 6'h23;
  localparam logic [5:0] OPC_SW    = 6'h2B;

  // R-type function codes
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_SRA  = 6'h03;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_XOR  = 6'h26;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLT  = 6'h2A;
  localparam logic [5:0] FN_SLTU = 6'h2B;

  typedef enum logic [3:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_AND,
    ALU_OR,
    ALU_XOR,
    ALU_NOR,
    ALU_SLT,
    ALU_SLTU,
    ALU_SLL,
    ALU_SRL,
    ALU_SRA
  } alu_op_t;

  // Decoded operation handed from the front end to the back end
  typedef struct packed {
    alu_op_t     op;
    logic [31:0] opa;
    logic [31:0] opb;
    logic [4:0]  shamt;
    logic [4:0]  dest;
    logic        is_load;
    logic        store_op;
  } exec_req_t;

endpackage

@@ hdl/miex_in_if.sv @@
// miex_in_if: instruction channel (instruction word plus two source values).
// Valid/ready handshake; no dependencies.
interface miex_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction_word;
  logic [31:0] rs_value;
  logic [31:0] rt_value;

  modport source (output valid, output instruction_word, output rs_value,
                  output rt_value, input ready);
  modport sink   (input valid, input instruction_word, input rs_value,
                  input rt_value, output ready);
endinterface

@@ hdl/miex_out_if.sv @@
// miex_out_if: result channel (ALU result, destination index, load/store flags).
// Valid/ready handshake; no dependencies.
interface miex_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] alu_out;
  logic [4:0]  dest_reg;
  logic        is_load;
  logic        store_op;

  modport source (output valid, output alu_out, output dest_reg,
                  output is_load, output store_op, input ready);
  modport sink   (input valid, input alu_out, input dest_reg,
                  input is_load, input store_op, output ready);
endinterface

@@ hdl/mips_integer_execute_unit.sv @@
// mips_integer_execute_unit: MIPS32 integer execute stage, top level.
// Depends on miex_pkg, miex_in_if, miex_out_if, miex_front, miex_queue, miex_back.
//
// Usage:
//   in_ch  carries one instruction word with its rs and rt register values;
//          a transfer happens on a rising clk edge with valid and ready high.
//   out_ch carries the ALU result, destination register index (rd for R-type,
//          rt otherwise) and the load/store word flags, same handshake.
//   The front end decodes each instruction straight into a request queue of
//   QUEUE_DEPTH entries; the back end runs the ALU and loads an output register.
// Path: each instruction passes through a queue slot and then the output
//   register before its result is offered on out_ch.
// Throughput: one instruction per cycle, set by the single ALU in the back end,
//   while out_ch.ready is high; the queue lets input and output transfer together.
// Stall: while out_ch.ready is low the result is held, the queue fills, and
//   in_ch.ready drops once QUEUE_DEPTH requests are waiting. Nothing is lost.
// Reset: synchronous active-low rst_n empties the queue and the output register;
//   there is no other state.
module mips_integer_execute_unit
  import miex_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
)(
  input  logic        clk,
  input  logic        rst_n,
  miex_in_if.sink     in_ch,
  miex_out_if.source  out_ch
);

  logic      q_push;
  logic      q_not_full;
  logic      q_pop;
  logic      q_not_empty;
  exec_req_t push_req;
  exec_req_t head_req;

  miex_front u_front (
    .in_ch   (in_ch),
    .q_ready (q_not_full),
    .q_push  (q_push),
    .q_req   (push_req)
  );

  miex_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_req  (push_req),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_req  (head_req)
  );

  miex_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_not_empty),
    .q_req   (head_req),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

@@ hdl/miex_front.sv @@
// miex_front: accepts instructions and decodes them into execute requests.
// Depends on miex_pkg and miex_in_if.
module miex_front
  import miex_pkg::*;
(
  miex_in_if.sink   in_ch,
  input  logic      q_ready,
  output logic      q_push,
  output exec_req_t q_req
);

  logic [5:0]  opcode;
  logic [5:0]  funct;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [31:0] imm_sext;

  assign opcode   = in_ch.instruction_word[31:26];
  assign rt       = in_ch.instruction_word[20:16];
  assign rd       = in_ch.instruction_word[15:11];
  assign funct    = in_ch.instruction_word[5:0];
  assign imm_sext = {{16{in_ch.instruction_word[15]}}, in_ch.instruction_word[15:0]};

  // Transfer into the queue whenever it has room
  assign in_ch.ready = q_ready;
  assign q_push      = in_ch.valid & q_ready;

  // Decode
  always_comb begin
    q_req.op       = ALU_ADD;
    q_req.opa      = in_ch.rs_value;
    q_req.opb      = in_ch.rt_value;
    q_req.shamt    = in_ch.instruction_word[10:6];
    q_req.dest     = rt;
    q_req.is_load  = (opcode == OPC_LW);
    q_req.store_op = (opcode == OPC_SW);

    if (opcode == OPC_RTYPE) begin
      q_req.dest = rd;
      case (funct)
        FN_ADD, FN_ADDU: q_req.op = ALU_ADD;
        FN_SUB, FN_SUBU: q_req.op = ALU_SUB;
        FN_AND:          q_req.op = ALU_AND;
        FN_OR:           q_req.op = ALU_OR;
        FN_XOR:          q_req.op = ALU_XOR;
        FN_NOR:          q_req.op = ALU_NOR;
        FN_SLT:          q_req.op = ALU_SLT;
        FN_SLTU:         q_req.op = ALU_SLTU;
        FN_SLL:          q_req.op = ALU_SLL;
        FN_SRL:          q_req.op = ALU_SRL;
        FN_SRA:          q_req.op = ALU_SRA;
        default:         q_req.op = ALU_ADD;   // unknown funct adds rs and rt
      endcase
    end else if (opcode inside {OPC_ADDI, OPC_ADDIU, OPC_LW, OPC_SW}) begin
      // immediate add and load/store address
      q_req.opb = imm_sext;
    end
  end

endmodule

@@ hdl/miex_queue.sv @@
// miex_queue: small FIFO of decoded requests between front and back ends.
// Depends on miex_pkg.
module miex_queue
  import miex_pkg::*;
#(
  parameter int unsigned DEPTH = 2
)(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  exec_req_t push_req,
  output logic      not_full,
  input  logic      pop,
  output logic      not_empty,
  output exec_req_t head_req
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  exec_req_t        entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign not_full  = (count_r != CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_req  = entry_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

@@ hdl/miex_back.sv @@
// miex_back: executes queued requests on the ALU and holds the result register.
// Depends on miex_pkg and miex_out_if.
module miex_back
  import miex_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  exec_req_t q_req,
  output logic      q_pop,
  miex_out_if.source out_ch
);

  logic        out_valid_r;
  logic [31:0] result_r;
  logic [4:0]  dest_r;
  logic        is_load_r;
  logic        store_op_r;
  logic [31:0] alu_nxt;

  // Take the next request when the result register is free or draining
  assign q_pop = q_valid & (~out_valid_r | out_ch.ready);

  // ALU
  always_comb begin
    case (q_req.op)
      ALU_ADD:  alu_nxt = q_req.opa + q_req.opb;
      ALU_SUB:  alu_nxt = q_req.opa - q_req.opb;
      ALU_AND:  alu_nxt = q_req.opa & q_req.opb;
      ALU_OR:   alu_nxt = q_req.opa | q_req.opb;
      ALU_XOR:  alu_nxt = q_req.opa ^ q_req.opb;
      ALU_NOR:  alu_nxt = ~(q_req.opa | q_req.opb);
      ALU_SLT:  alu_nxt = {31'd0, $signed(q_req.opa) < $signed(q_req.opb)};
      ALU_SLTU: alu_nxt = {31'd0, q_req.opa < q_req.opb};
      ALU_SLL:  alu_nxt = q_req.opb << q_req.shamt;
      ALU_SRL:  alu_nxt = q_req.opb >> q_req.shamt;
      ALU_SRA:  alu_nxt = 32'($signed(q_req.opb) >>> q_req.shamt);
      default:  alu_nxt = q_req.opa + q_req.opb;
    endcase
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      result_r   <= alu_nxt;
      dest_r     <= q_req.dest;
      is_load_r  <= q_req.is_load;
      store_op_r <= q_req.store_op;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.alu_out  = result_r;
  assign out_ch.dest_reg = dest_r;
  assign out_ch.is_load  = is_load_r;
  assign out_ch.store_op = store_op_r;

endmodule
